FILE: rtl/core/assert_macros.svh
// Assertion macros for the timer table RTL.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ptt_pkg.sv
// Shared types, codes and constants for the periodic timer table.
// No dependencies.
package ptt_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_W = 32;
  localparam int WAIT_W = 16;
  localparam logic [WAIT_W-1:0] DEFAULT_WAIT_RESET = 16'd300;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_DISARM = 2'd2,
    OP_MODIFY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_ALREADY_ARMED = 2'd1,
    ST_NOT_ARMED     = 2'd2
  } status_t;

  typedef enum logic {
    KIND_FIRED = 1'b0,
    KIND_FINAL = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FIN
  } state_t;

  // operands of the shared adder
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_ctl_t;

endpackage

FILE: rtl/core/ptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ptt_alu.sv
// Shared 32-bit add/subtract unit used by every step of the sequencer.
// Depends on ptt_pkg.
module ptt_alu
  import ptt_pkg::*;
(
  input  alu_ctl_t          ctl,
  output logic [TIME_W-1:0] sum
);

  logic [TIME_W-1:0] b_eff;

  assign b_eff = ctl.sub ? ~ctl.b : ctl.b;
  assign sum   = ctl.a + b_eff + {{(TIME_W-1){1'b0}}, ctl.sub};

endmodule

FILE: rtl/core/periodic_timer_table.sv
// Periodic timer table top level: sequencer, armed bits, time counter, output register.
// Depends on ptt_pkg, ptt_ram, ptt_alu and assert_macros.svh.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------
//  command   | start / busy         | operation, slot, period_ms
//  result    | strobe (no stall)    | kind, fired_slot, status, wait_ms, last
//  config    | cfg_write            | cfg_data (default wait)
//
// Busy stays high after acceptance through the walk, drain and final states: one slot
// per cycle is walked through the period/deadline RAMs (single read port each), then
// a drain state and a final state for the wait subtract. The final result is on the
// ports in the same cycle that busy falls, when a new command can be accepted.
// Fired results come out at most one per cycle during the walk; the final result follows.
// Synchronous reset clears time and armed bits and loads DEFAULT_WAIT_RESET into the
// default wait; the RAMs are not cleared, entries are only used once armed.
`include "assert_macros.svh"

module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [3:0]        slot,
  input  logic [TIME_W-1:0] period_ms,
  input  logic              cfg_write,
  input  logic [WAIT_W-1:0] cfg_data,
  output logic              strobe,
  output logic              kind,
  output logic [3:0]        fired_slot,
  output logic [1:0]        status,
  output logic [WAIT_W-1:0] wait_ms,
  output logic              last
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  state_t state, state_next;

  logic [TIME_W-1:0]     now_ms;
  logic [NUM_TIMERS-1:0] armed;
  logic [WAIT_W-1:0]     default_wait;
  logic [TIME_W-1:0]     best;
  logic                  any;
  logic                  op_tick;
  status_t               st_reg;
  logic [IW-1:0]         cnt;
  logic [IW-1:0]         pidx;
  logic                  pv;

  logic                  accept;
  op_t                   op_in;
  logic [IW-1:0]         slot_idx;
  logic                  slot_ok;
  logic                  slot_armed;
  logic                  arm_ok;
  logic                  disarm_ok;
  logic                  mod_ok;
  status_t               st_in;

  alu_ctl_t              alu_ctl;
  logic [TIME_W-1:0]     sum;
  logic [TIME_W-1:0]     rd_period;
  logic [TIME_W-1:0]     rd_dl;

  logic                  ev_armed;
  logic                  fire;
  logic [TIME_W-1:0]     cand;
  logic                  take;

  logic                  per_we;
  logic                  dl_we;
  logic [IW-1:0]         waddr;

  logic [WAIT_W-1:0]     wait_calc;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign op_in  = op_t'(operation);

  assign slot_idx   = IW'(slot);
  assign slot_ok    = (32'(slot) < NUM_TIMERS);
  assign slot_armed = slot_ok && armed[slot_idx];
  assign arm_ok     = (op_in == OP_ARM) && slot_ok && !slot_armed;
  assign disarm_ok  = (op_in == OP_DISARM) && slot_armed;
  assign mod_ok     = (op_in == OP_MODIFY) && slot_ok;

  always_comb begin
    st_in = ST_OK;
    if (op_in != OP_TICK) begin
      if (!slot_ok) begin
        st_in = ST_NOT_ARMED;
      end else if (op_in == OP_ARM && slot_armed) begin
        st_in = ST_ALREADY_ARMED;
      end else if (op_in == OP_DISARM && !slot_armed) begin
        st_in = ST_NOT_ARMED;
      end
    end
  end

  // evaluation stage, in the cycle after the RAM read address
  assign ev_armed = pv && armed[pidx];
  assign fire     = ev_armed && op_tick && (now_ms >= rd_dl);
  assign cand     = fire ? sum : rd_dl;
  assign take     = ev_armed && (!any || cand < best);

  ptt_alu u_alu (
    .ctl (alu_ctl),
    .sum (sum)
  );

  ptt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_period (
    .clk   (clk),
    .we    (per_we),
    .waddr (waddr),
    .wdata (period_ms),
    .raddr (cnt),
    .rdata (rd_period)
  );

  ptt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_deadline (
    .clk   (clk),
    .we    (dl_we),
    .waddr (waddr),
    .wdata (sum),
    .raddr (cnt),
    .rdata (rd_dl)
  );

  // wait from the earliest deadline; sum holds best - now in the final step
  always_comb begin
    if (!any) begin
      wait_calc = default_wait;
    end else if (best <= now_ms) begin
      wait_calc = '0;
    end else if (sum > {{(TIME_W-WAIT_W){1'b0}}, default_wait}) begin
      wait_calc = default_wait;
    end else begin
      wait_calc = sum[WAIT_W-1:0];
    end
  end

  always_comb begin
    state_next  = state;
    alu_ctl.a   = now_ms;
    alu_ctl.b   = rd_period;
    alu_ctl.sub = 1'b0;
    per_we      = 1'b0;
    dl_we       = 1'b0;
    waddr       = pidx;
    case (state)
      S_IDLE: begin
        alu_ctl.b = (op_in == OP_TICK) ? {{(TIME_W-1){1'b0}}, 1'b1} : period_ms;
        waddr     = slot_idx;
        if (accept) begin
          per_we     = arm_ok || mod_ok;
          dl_we      = arm_ok || (mod_ok && slot_armed);
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        dl_we = fire;
        if (cnt == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        dl_we      = fire;
        state_next = S_FIN;
      end
      S_FIN: begin
        alu_ctl.a   = best;
        alu_ctl.b   = now_ms;
        alu_ctl.sub = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms       <= '0;
      armed        <= '0;
      default_wait <= DEFAULT_WAIT_RESET;
      pv           <= 1'b0;
      cnt          <= '0;
      strobe       <= 1'b0;
    end else begin
      if (cfg_write) begin
        default_wait <= cfg_data;
      end
      pv     <= (state == S_WALK);
      strobe <= fire || (state == S_FIN);
      if (accept) begin
        cnt <= '0;
        if (op_in == OP_TICK) begin
          now_ms <= sum;
        end
        if (arm_ok) begin
          armed[slot_idx] <= 1'b1;
        end
        if (disarm_ok) begin
          armed[slot_idx] <= 1'b0;
        end
      end else if (state == S_WALK && cnt != LAST_IDX) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // transaction payload and walk registers
  always_ff @(posedge clk) begin
    pidx <= cnt;
    if (accept) begin
      op_tick <= (op_in == OP_TICK);
      st_reg  <= st_in;
      any     <= 1'b0;
    end else if (take) begin
      best <= cand;
      any  <= 1'b1;
    end
    if (state == S_FIN) begin
      kind       <= KIND_FINAL;
      fired_slot <= '0;
      status     <= st_reg;
      wait_ms    <= wait_calc;
      last       <= 1'b1;
    end else begin
      kind       <= KIND_FIRED;
      fired_slot <= 4'(pidx);
      status     <= ST_OK;
      wait_ms    <= '0;
      last       <= 1'b0;
    end
  end

  `CHK_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
  `CHK_NEXT(a_final_alone, strobe && kind == KIND_FINAL, !strobe, "result after final")
  `CHK_NOW(a_fired_busy, strobe && kind == KIND_FIRED, busy, "fired result while idle")
  `CHK_NEXT(a_fin_result, state == S_FIN, strobe && last, "final result missing")

endmodule
